@@ src/edcc_pkg.sv @@
`default_nettype none
package edcc_pkg;

	// CD-ROM EDC polynomial, reflected form
	localparam logic [31:0] EDC_POLY = 32'hd801_8001;

	localparam logic KIND_USER   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] user_byte;
		logic       item_kind;
		logic       edc_match;
		logic       track_error;
	} res_t;

	// One byte of the reflected CRC, eight shift steps unrolled
	function automatic logic [31:0] edc_byte_update(input logic [31:0] crc,
			input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ EDC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/edcc_out_buf.sv @@
`default_nettype none
module edcc_out_buf
	import edcc_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push,
	input  wire res_t push_word,
	output logic      space,
	output logic      out_valid,
	input  wire       out_ready,
	output res_t      out_word
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;

	// a push is only offered while the skid slot is free
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (!main_valid_q) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_valid_q && out_ready) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_word;
			end
		end else if (!main_valid_q) begin
			if (push) begin
				main_q <= push_word;
			end
		end else if (push) begin
			skid_q <= push_word;
		end
	end

endmodule
`default_nettype wire

@@ src/cdrom_mode1_sector_edc_checker.sv @@
// CD-ROM Mode 1 sector EDC checker.
// Input channel (in_valid/in_ready): one raw sector byte per word, plus
// track_start on the first byte of a new track. The stream must be sector
// aligned after reset; 2352 bytes make one sector.
// Output channel (out_valid/out_ready): item_kind 0 carries a user byte
// (sector offsets 16..2063); item_kind 1 is the sector status, pushed on
// the last stored EDC byte (offset 2067), with edc_match and the sticky
// per-track track_error flag. Other offsets produce no output word.
// Throughput: one input word per cycle while in_ready is high. The EDC is
// a byte-wide parallel CRC update between the state registers. A result
// is registered in the output buffer before it shows on out_valid.
// Stall: results go into an output register backed by one skid entry;
// in_ready falls only when both hold a word, so bytes with no result and
// the next byte keep flowing while out_ready is low, until the skid fills.
// Reset (arst_n low): position, EDC, mismatch and sticky error go to zero,
// output buffer empties.
`default_nettype none
module cdrom_mode1_sector_edc_checker
	import edcc_pkg::*;
#(
	parameter int SECTOR_BYTES = 2352,
	parameter int HEADER_BYTES = 16,
	parameter int USER_BYTES   = 2048
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] data_byte,
	input  wire        track_start,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] user_byte,
	output logic       item_kind,
	output logic       edc_match,
	output logic       track_error
);

	localparam int POS_W   = $clog2(SECTOR_BYTES);
	localparam int EDC_END = HEADER_BYTES + USER_BYTES;

	localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0] POS_EDC_END = POS_W'(EDC_END);
	localparam logic [POS_W-1:0] POS_EDC_LST = POS_W'(EDC_END + 3);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(SECTOR_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	logic             mismatch_q;
	logic             sticky_q;

	logic             accept;
	logic             in_edc;
	logic             in_user;
	logic             in_stored;
	logic             last_stored;
	logic [POS_W-1:0] k_full;
	logic [1:0]       k;
	logic [7:0]       expect_byte;
	logic             mismatch_nxt;
	logic             sticky_clr;
	logic             sticky_nxt;
	logic [31:0]      crc_upd;
	logic             push;
	res_t             push_word;
	res_t             out_word;
	logic             buf_space;

	assign accept = in_valid && in_ready;

	// decode where in the sector this byte sits
	assign in_edc      = pos_q < POS_EDC_END;
	assign in_user     = in_edc && (pos_q >= POS_HDR_END);
	assign in_stored   = (pos_q >= POS_EDC_END) && (pos_q <= POS_EDC_LST);
	assign last_stored = pos_q == POS_EDC_LST;
	assign k_full      = pos_q - POS_EDC_END;
	assign k           = k_full[1:0];

	// stored EDC is little endian: byte k against crc bits 8k+7..8k
	assign expect_byte = crc_q[8*k +: 8];
	assign mismatch_nxt = mismatch_q || (in_stored && (expect_byte != data_byte));

	// track start clears the flag before this byte counts
	assign sticky_clr = track_start ? 1'b0 : sticky_q;
	assign sticky_nxt = sticky_clr || (last_stored && mismatch_nxt);

	assign crc_upd = edc_byte_update(crc_q, data_byte);

	always_comb begin
		push_word.user_byte   = data_byte;
		push_word.item_kind   = KIND_USER;
		push_word.edc_match   = 1'b0;
		push_word.track_error = sticky_clr;
		push = 1'b0;
		if (in_user) begin
			push = accept;
		end else if (last_stored) begin
			push = accept;
			push_word.user_byte   = 8'd0;
			push_word.item_kind   = KIND_STATUS;
			push_word.edc_match   = !mismatch_nxt;
			push_word.track_error = sticky_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= '0;
			mismatch_q <= 1'b0;
			sticky_q   <= 1'b0;
		end else if (accept) begin
			sticky_q <= sticky_nxt;
			if (pos_q == POS_LAST) begin
				pos_q      <= '0;
				crc_q      <= '0;
				mismatch_q <= 1'b0;
			end else begin
				pos_q      <= pos_q + 1'b1;
				mismatch_q <= mismatch_nxt;
				if (in_edc) begin
					crc_q <= crc_upd;
				end
			end
		end
	end

	edcc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.space     (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	assign in_ready    = buf_space;
	assign user_byte   = out_word.user_byte;
	assign item_kind   = out_word.item_kind;
	assign edc_match   = out_word.edc_match;
	assign track_error = out_word.track_error;

`ifndef NO_ASSERTIONS
	// a status word only comes from the last stored EDC byte
	a_status_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_word.item_kind == KIND_STATUS) |-> (pos_q == POS_EDC_LST))
		else $error("status word pushed off the last EDC byte");

	// sector wrap clears the per-sector state
	a_wrap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == POS_LAST) |=> (pos_q == '0 && crc_q == '0 && !mismatch_q))
		else $error("sector wrap left stale EDC state");

	// input only backs up when a result is actually waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with output buffer empty");
`endif

endmodule
`default_nettype wire
